// ----- src/ffa_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit heap allocator core: field
// widths, register indexes, operation and status codes, sequencer states.
// ---------------------------------------------------------------------------
package ffa_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_SEGMENTS_DEF = 64;
  localparam int unsigned OFFSET_BITS_DEF  = 24;

  // Fixed field widths.
  localparam int unsigned ARENA_W    = 25;
  localparam int unsigned HDR_W      = 7;
  localparam int unsigned REQ_W      = 24;
  localparam int unsigned OUT_W      = 24;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 25;

  // Register reset values.
  localparam logic [ARENA_W-1:0] ARENA_RESET = 25'h100_0000;
  localparam logic [HDR_W-1:0]   HDR_RESET   = 7'd32;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_ARENA  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 4'd1;

  // Operation codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_ZERO     = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_NBR,
    S_MOVE,
    S_FIN,
    S_FIN2
  } state_e;

  // Verdict of the segment compare unit for one table entry.
  typedef struct packed {
    logic hit;   // allocate: free and large enough; free: start matches
    logic room;  // remainder after the grant exceeds one header
  } eval_t;

endpackage
`default_nettype wire

// ----- src/first_fit_heap_allocator_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_core
// An allocate or free scans the table one entry per cycle through the table
// memory read port up to the matching segment, then shifts the entries
// that follow on a split or merge, and ends with one or two write-back
// steps. Requests of zero size, null frees and short offsets are answered
// from the idle state without a scan. One request at a time.
// Reset, and any write to a register, rebuilds the table as one free segment
// covering the arena while busy is high.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator_core
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int unsigned OFFSET_BITS  = OFFSET_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           func_i,
  input  logic [ffa_pkg::REQ_W-1:0]      request_bytes_i,
  input  logic [ffa_pkg::REQ_W-1:0]      release_offset_i,
  output logic                           done_o,
  output logic [ffa_pkg::OUT_W-1:0]      payload_offset_o,
  output logic [ffa_pkg::STATUS_W-1:0]   status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ffa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ffa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LEN_W  = OFFSET_BITS + 1;
  localparam int unsigned IW     = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW     = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned NEED_W = ((LEN_W > REQ_W + 1) ? LEN_W : REQ_W + 1) + 1;
  localparam int unsigned AW     = (LEN_W > ARENA_W) ? LEN_W : ARENA_W;
  localparam int unsigned OSW    = (OFFSET_BITS > OUT_W) ? OFFSET_BITS : OUT_W;
  localparam logic [AW-1:0] ARENA_CAP = AW'(1) << OFFSET_BITS;

  typedef struct packed {
    logic                   used;
    logic [LEN_W-1:0]       len;
    logic [OFFSET_BITS-1:0] start;
  } seg_t;

  // Segment table.
  seg_t seg_mem [MAX_SEGMENTS];

  state_e                 state_q, state_d;
  logic [ARENA_W-1:0]     arena_q, arena_d;
  logic [HDR_W-1:0]       hdr_q, hdr_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   vld_q, vld_d;
  logic                   pend_q, pend_d;
  logic                   done_q, done_d;
  logic [CW-1:0]          mv_cnt_q, mv_cnt_d;

  logic                   func_q, func_d;
  logic [NEED_W-1:0]      need_q, need_d;
  logic [NEED_W-1:0]      need2_q, need2_d;
  logic [REQ_W-1:0]       target_q, target_d;
  logic [CW-1:0]          issue_q, issue_d;
  logic [IW-1:0]          chk_q, chk_d;
  seg_t                   rd_q;
  seg_t                   prev_q, prev_d;
  logic [IW-1:0]          hit_idx_q, hit_idx_d;
  logic [OFFSET_BITS-1:0] hit_start_q, hit_start_d;
  logic [LEN_W-1:0]       hit_len_q, hit_len_d;
  logic                   split_q, split_d;
  logic                   nf_q, nf_d;
  logic                   pf_q, pf_d;
  logic [LEN_W-1:0]       sum_q, sum_d;
  logic [IW-1:0]          mv_src_q, mv_src_d;
  logic                   mv_right_q, mv_right_d;
  logic                   mv_two_q, mv_two_d;
  logic [IW-1:0]          pend_dst_q, pend_dst_d;
  logic [OUT_W-1:0]       off_q, off_d;
  status_e                st_q, st_d;

  logic                   mem_we, mem_re;
  logic [IW-1:0]          mem_waddr, mem_raddr;
  seg_t                   mem_wdata;

  logic [HDR_W-1:0]       hdr_eff;
  logic [AW-1:0]          arena_ext;
  logic [LEN_W-1:0]       arena_eff;
  logic [OSW-1:0]         grant_sum;
  eval_t                  eval;

  assign hdr_eff   = (hdr_q == '0) ? HDR_W'(1) : hdr_q;
  assign arena_ext = AW'(arena_q);
  assign arena_eff = LEN_W'((arena_ext > ARENA_CAP) ? ARENA_CAP : arena_ext);
  assign grant_sum = OSW'(hit_start_q) + OSW'(hdr_eff);

  ffa_cmp_unit #(
    .LEN_W  (LEN_W),
    .OFF_W  (OFFSET_BITS),
    .NEED_W (NEED_W),
    .TGT_W  (REQ_W)
  ) u_cmp (
    .func_i      (func_q),
    .seg_used_i  (rd_q.used),
    .seg_len_i   (rd_q.len),
    .seg_start_i (rd_q.start),
    .need_i      (need_q),
    .need2_i     (need2_q),
    .target_i    (target_q),
    .eval_o      (eval)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= seg_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      arena_q  <= ARENA_RESET;
      hdr_q    <= HDR_RESET;
      count_q  <= CW'(1);
      vld_q    <= 1'b0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      mv_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      arena_q  <= arena_d;
      hdr_q    <= hdr_d;
      count_q  <= count_d;
      vld_q    <= vld_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
      mv_cnt_q <= mv_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    need_q      <= need_d;
    need2_q     <= need2_d;
    target_q    <= target_d;
    issue_q     <= issue_d;
    chk_q       <= chk_d;
    prev_q      <= prev_d;
    hit_idx_q   <= hit_idx_d;
    hit_start_q <= hit_start_d;
    hit_len_q   <= hit_len_d;
    split_q     <= split_d;
    nf_q        <= nf_d;
    pf_q        <= pf_d;
    sum_q       <= sum_d;
    mv_src_q    <= mv_src_d;
    mv_right_q  <= mv_right_d;
    mv_two_q    <= mv_two_d;
    pend_dst_q  <= pend_dst_d;
    off_q       <= off_d;
    st_q        <= st_d;
  end

  always_comb begin
    logic nf;
    logic pf;

    state_d     = state_q;
    arena_d     = arena_q;
    hdr_d       = hdr_q;
    count_d     = count_q;
    pend_d      = 1'b0;
    done_d      = 1'b0;
    mv_cnt_d    = mv_cnt_q;
    func_d      = func_q;
    need_d      = need_q;
    need2_d     = need2_q;
    target_d    = target_q;
    issue_d     = issue_q;
    chk_d       = chk_q;
    prev_d      = prev_q;
    hit_idx_d   = hit_idx_q;
    hit_start_d = hit_start_q;
    hit_len_d   = hit_len_q;
    split_d     = split_q;
    nf_d        = nf_q;
    pf_d        = pf_q;
    sum_d       = sum_q;
    mv_src_d    = mv_src_q;
    mv_right_d  = mv_right_q;
    mv_two_d    = mv_two_q;
    pend_dst_d  = pend_dst_q;
    off_d       = off_q;
    st_d        = st_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = '0;
    mem_raddr   = '0;
    mem_wdata   = '0;
    nf          = 1'b0;
    pf          = 1'b0;

    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{used: 1'b0, len: arena_eff, start: '0};
        count_d   = CW'(1);
        state_d   = S_IDLE;
      end

      S_IDLE: begin
        if (start_i) begin
          func_d   = func_i;
          need_d   = NEED_W'(request_bytes_i) + NEED_W'(hdr_eff);
          need2_d  = NEED_W'(request_bytes_i) + (NEED_W'(hdr_eff) << 1);
          target_d = release_offset_i - REQ_W'(hdr_eff);
          issue_d  = '0;
          off_d    = '0;
          if (func_i == FUNC_ALLOC) begin
            if (request_bytes_i == '0) begin
              st_d   = ST_ZERO;
              done_d = 1'b1;
            end else begin
              state_d = S_SCAN;
            end
          end else if (release_offset_i == '0) begin
            st_d   = ST_IGNORED;
            done_d = 1'b1;
          end else if (release_offset_i < REQ_W'(hdr_eff)) begin
            st_d   = ST_NOTFOUND;
            done_d = 1'b1;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Reads are issued one entry ahead of the compare.
        if (issue_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = issue_q[IW-1:0];
          issue_d   = issue_q + CW'(1);
        end
        chk_d = issue_q[IW-1:0];
        if (vld_q) begin
          if (eval.hit) begin
            hit_idx_d   = chk_q;
            hit_start_d = rd_q.start;
            hit_len_d   = rd_q.len;
            if (func_q == FUNC_ALLOC) begin
              split_d    = eval.room && (count_q < CW'(MAX_SEGMENTS));
              mv_right_d = 1'b1;
              mv_two_d   = 1'b0;
              mv_src_d   = IW'(count_q - CW'(1));
              mv_cnt_d   = (eval.room && (count_q < CW'(MAX_SEGMENTS))) ?
                           (count_q - CW'(1) - CW'(chk_q)) : '0;
              state_d    = S_MOVE;
            end else if (!rd_q.used) begin
              st_d    = ST_IGNORED;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_NBR;
            end
          end else begin
            prev_d = rd_q;
            if (chk_q == IW'(count_q - CW'(1))) begin
              st_d    = (func_q == FUNC_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end
        end
      end

      S_NBR: begin
        // The read of the successor was issued during the last scan cycle.
        nf         = vld_q && !rd_q.used;
        pf         = (hit_idx_q != '0) && !prev_q.used;
        nf_d       = nf;
        pf_d       = pf;
        sum_d      = hit_len_q + (nf ? rd_q.len : '0);
        mv_right_d = 1'b0;
        mv_two_d   = nf && pf;
        mv_src_d   = hit_idx_q + IW'(1) + IW'(nf);
        mv_cnt_d   = (nf || pf) ?
                     (count_q - CW'(hit_idx_q) - CW'(1) - CW'(nf)) : '0;
        state_d    = S_MOVE;
      end

      S_MOVE: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pend_dst_q;
          mem_wdata = rd_q;
        end
        if (mv_cnt_q != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = mv_src_q;
          pend_d     = 1'b1;
          pend_dst_d = mv_right_q ? (mv_src_q + IW'(1)) :
                       (mv_src_q - (mv_two_q ? IW'(2) : IW'(1)));
          mv_src_d   = mv_right_q ? (mv_src_q - IW'(1)) : (mv_src_q + IW'(1));
          mv_cnt_d   = mv_cnt_q - CW'(1);
        end else begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        mem_we = 1'b1;
        if (func_q == FUNC_ALLOC) begin
          if (split_q) begin
            mem_waddr = hit_idx_q + IW'(1);
            mem_wdata = '{used:  1'b0,
                          len:   hit_len_q - need_q[LEN_W-1:0],
                          start: hit_start_q + OFFSET_BITS'(need_q)};
            state_d   = S_FIN2;
          end else begin
            mem_waddr = hit_idx_q;
            mem_wdata = '{used: 1'b1, len: hit_len_q, start: hit_start_q};
            off_d     = grant_sum[OUT_W-1:0];
            st_d      = ST_OK;
            done_d    = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          mem_waddr = pf_q ? (hit_idx_q - IW'(1)) : hit_idx_q;
          mem_wdata = '{used:  1'b0,
                        len:   sum_q + (pf_q ? prev_q.len : '0),
                        start: pf_q ? prev_q.start : hit_start_q};
          count_d   = count_q - CW'(nf_q) - CW'(pf_q);
          off_d     = '0;
          st_d      = ST_OK;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_FIN2: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx_q;
        mem_wdata = '{used: 1'b1, len: need_q[LEN_W-1:0], start: hit_start_q};
        count_d   = count_q + CW'(1);
        off_d     = grant_sum[OUT_W-1:0];
        st_d      = ST_OK;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_INIT;
      end
    endcase

    vld_d = (state_q == S_SCAN) && mem_re;

    // A register write rebuilds the table from scratch.
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ARENA: begin
          arena_d = cfg_data_i[ARENA_W-1:0];
          state_d = S_INIT;
        end
        REG_HEADER: begin
          hdr_d   = cfg_data_i[HDR_W-1:0];
          state_d = S_INIT;
        end
        default: begin
        end
      endcase
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign done_o           = done_q;
  assign payload_offset_o = off_q;
  assign status_o         = st_q;

endmodule
`default_nettype wire

// ----- src/ffa_cmp_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ffa_cmp_unit
// Segment compare unit shared by every step of a table scan: checks one
// entry against the pending allocate size or the pending free address.
// ---------------------------------------------------------------------------
module ffa_cmp_unit #(
  parameter int unsigned LEN_W  = 25,
  parameter int unsigned OFF_W  = 24,
  parameter int unsigned NEED_W = 26,
  parameter int unsigned TGT_W  = 24
) (
  input  logic                func_i,
  input  logic                seg_used_i,
  input  logic [LEN_W-1:0]    seg_len_i,
  input  logic [OFF_W-1:0]    seg_start_i,
  input  logic [NEED_W-1:0]   need_i,
  input  logic [NEED_W-1:0]   need2_i,
  input  logic [TGT_W-1:0]    target_i,
  output ffa_pkg::eval_t      eval_o
);
  import ffa_pkg::*;

  localparam int unsigned SW = (OFF_W > TGT_W) ? OFF_W : TGT_W;

  logic [NEED_W-1:0] len_ext;
  logic              start_eq;

  assign len_ext  = NEED_W'(seg_len_i);
  assign start_eq = (SW'(seg_start_i) == SW'(target_i));

  always_comb begin
    eval_o.room = (len_ext > need2_i);
    if (func_i == FUNC_ALLOC) begin
      eval_o.hit = !seg_used_i && (len_ext >= need_i);
    end else begin
      eval_o.hit = start_eq;
    end
  end

endmodule
`default_nettype wire
